@@ rtl/core/lcdn_pkg.sv @@
package lcdn_pkg;

  localparam int DISPLAY_CELLS = 16;
  localparam int CELL_W        = $clog2(DISPLAY_CELLS);

  // display windows: 0x80..0x87 -> cells 0..7, 0xC0..0xC7 -> cells 8..15
  localparam logic [4:0] ROW0_BASE = 5'b10000;
  localparam logic [4:0] ROW1_BASE = 5'b11000;

  typedef enum logic [1:0] {
    ACT_SET_RS  = 2'd0,
    ACT_SET_RW  = 2'd1,
    ACT_SET_EN  = 2'd2,
    ACT_NIBBLE  = 2'd3
  } action_t;

  typedef logic [DISPLAY_CELLS-1:0][7:0] cells_t;

  typedef struct packed {
    logic       reg_select;
    logic       read_not_write;
    logic [3:0] enable_level;
    logic [3:0] latched_nibble;
    logic [7:0] assembled_byte;
    logic       low_nibble_phase;
    logic [7:0] write_address;
  } lcd_state_t;

  // first member is the top bit: byte_complete lands at bit 0
  typedef struct packed {
    logic              pad;
    logic [7:0]        current_address;
    logic              redraw_request;
    logic [7:0]        display_char;
    logic [CELL_W-1:0] display_pos;
    logic              display_write;
    logic [7:0]        byte_value;
    logic              byte_complete;
  } result_t;

  typedef struct packed {
    logic              we;
    logic [CELL_W-1:0] idx;
    logic [7:0]        data;
  } cell_wr_t;

endpackage

@@ rtl/core/lcdn_step.sv @@
module lcdn_step (
  input  lcdn_pkg::lcd_state_t cur,
  input  lcdn_pkg::cells_t     cells,
  input  lcdn_pkg::action_t    action,
  input  logic [3:0]           value,
  output lcdn_pkg::lcd_state_t nxt,
  output lcdn_pkg::cell_wr_t   cell_wr,
  output lcdn_pkg::result_t    res
);

  logic       hit;
  logic [7:0] new_byte;

  always_comb begin
    nxt      = cur;
    res      = '0;
    cell_wr  = '0;
    hit      = 1'b0;
    new_byte = cur.assembled_byte;
    case (action)
      lcdn_pkg::ACT_SET_RS: nxt.reg_select     = (value != 4'd0);
      lcdn_pkg::ACT_SET_RW: nxt.read_not_write = (value != 4'd0);
      lcdn_pkg::ACT_NIBBLE: nxt.latched_nibble = value;
      lcdn_pkg::ACT_SET_EN: begin
        if (value != cur.enable_level) begin
          nxt.enable_level = value;
          // any edge that does not land on level 1 takes the nibble
          if (value != 4'd1) begin
            nxt.low_nibble_phase = ~cur.low_nibble_phase;
            if (!cur.low_nibble_phase) begin
              new_byte = {cur.latched_nibble, cur.assembled_byte[3:0]};
            end else begin
              new_byte          = {cur.assembled_byte[7:4], cur.latched_nibble};
              res.byte_complete = 1'b1;
              if (!cur.reg_select && !cur.read_not_write) begin
                nxt.write_address = new_byte;
              end else if (!cur.read_not_write) begin
                hit = (cur.write_address[7:3] == lcdn_pkg::ROW0_BASE) ||
                      (cur.write_address[7:3] == lcdn_pkg::ROW1_BASE);
                cell_wr.idx  = {cur.write_address[6], cur.write_address[2:0]};
                cell_wr.data = new_byte;
                cell_wr.we   = hit;
                if (hit) begin
                  res.display_write  = 1'b1;
                  res.display_pos    = cell_wr.idx;
                  res.display_char   = new_byte;
                  res.redraw_request = (cells[cell_wr.idx] != new_byte);
                end
                nxt.write_address = cur.write_address + 8'd1;
              end
            end
          end
        end
      end
      default: nxt = cur;
    endcase
    nxt.assembled_byte  = new_byte;
    res.byte_value      = new_byte;
    res.current_address = nxt.write_address;
  end

endmodule

@@ rtl/core/lcd_nibble_interface_controller_core.sv @@
// Pin-event decoder for a character LCD on a 4-bit bus.
// An accepted input beat waits in the input register until the result stage
// can take it; the state update then feeds the result register. Throughput:
// one beat per cycle unless the output stalls; state is read and written in
// one stage. Reset (rst_n low, synchronous) clears pins, nibble phase,
// address and all 16 display cells to zero and empties both pipeline registers.
module lcd_nibble_interface_controller_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [1:0] action, [5:2] value, [7:6] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [0] byte_complete, [8:1] byte_value,
                                  // [9] display_write, [13:10] display_pos,
                                  // [21:14] display_char, [22] redraw_request,
                                  // [30:23] current_address, [31] zero
);

  logic                 in_valid_r;
  lcdn_pkg::action_t    action_r;
  logic [3:0]           value_r;
  logic                 out_valid_r;
  lcdn_pkg::result_t    res_r;
  lcdn_pkg::result_t    res_nxt;
  lcdn_pkg::lcd_state_t state_r;
  lcdn_pkg::lcd_state_t state_nxt;
  lcdn_pkg::cells_t     cells_r;
  lcdn_pkg::cell_wr_t   cell_wr;
  logic                 advance;

  assign advance    = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !in_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r;

  lcdn_step u_step (
    .cur     (state_r),
    .cells   (cells_r),
    .action  (action_r),
    .value   (value_r),
    .nxt     (state_nxt),
    .cell_wr (cell_wr),
    .res     (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  // hold the input beat until the result stage can take it
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      action_r <= lcdn_pkg::action_t'(in_tdata[1:0]);
      value_r  <= in_tdata[5:2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      state_r     <= '0;
      cells_r     <= '0;
    end else begin
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
        if (cell_wr.we) begin
          cells_r[cell_wr.idx] <= cell_wr.data;
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  a_write_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.display_write |-> res_r.byte_complete)
    else $error("display write without a completed byte");

  a_redraw_needs_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.redraw_request |-> res_r.display_write)
    else $error("redraw flagged without a display write");

  a_hold_stalled_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(value_r) && $stable(action_r))
    else $error("stalled input beat was lost");

  a_state_only_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(state_r) && $stable(cells_r))
    else $error("state changed without a processed beat");

endmodule

@@ dv/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         LIMIT_CYCLES = 200000;
  localparam logic [3:0] EN_HIGH      = 4'd1;
  localparam logic [7:0] ROW0_FIRST   = 8'h80;
  localparam logic [7:0] ROW0_LAST    = 8'h87;
  localparam logic [7:0] ROW1_FIRST   = 8'hC0;
  localparam logic [7:0] ROW1_LAST    = 8'hC7;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;

  lcd_nibble_interface_controller_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  // pin events waiting to be driven and results waiting to be seen
  logic [7:0]        pin_event_queue[$];
  lcdn_pkg::result_t lcd_result_queue[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int holdoff_left   = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;
  bit in_fire        = 1'b0;

  // shadow of the controller state
  logic       lcd_rs;
  logic       lcd_rw;
  logic [3:0] lcd_en;
  logic [3:0] lcd_nibble;
  logic [7:0] lcd_byte;
  logic       lcd_low_phase;
  logic [7:0] lcd_addr;
  logic [7:0] lcd_cells[lcdn_pkg::DISPLAY_CELLS];

  // generator's view of the enable pin and nibble phase
  logic [3:0] gen_en    = 4'd0;
  logic       gen_phase = 1'b0;
  int         gen_count = 0;

  lcdn_pkg::result_t got_result;
  lcdn_pkg::result_t want_result;

  function automatic lcdn_pkg::result_t predict_pin_event(input lcdn_pkg::action_t act,
                                                           input logic [3:0] val);
    lcdn_pkg::result_t r;
    logic              hit;
    logic [3:0]        cell_idx;
    r        = '0;
    hit      = 1'b0;
    cell_idx = '0;
    case (act)
      lcdn_pkg::ACT_SET_RS: lcd_rs = (val != 4'd0);
      lcdn_pkg::ACT_SET_RW: lcd_rw = (val != 4'd0);
      lcdn_pkg::ACT_NIBBLE: lcd_nibble = val;
      default: begin
        if (val != lcd_en) begin
          lcd_en = val;
          if (val != EN_HIGH) begin
            if (!lcd_low_phase) begin
              lcd_byte = {lcd_nibble, lcd_byte[3:0]};
            end else begin
              lcd_byte        = {lcd_byte[7:4], lcd_nibble};
              r.byte_complete = 1'b1;
              if (!lcd_rs && !lcd_rw) begin
                lcd_addr = lcd_byte;
              end else if (!lcd_rw) begin
                if (lcd_addr >= ROW0_FIRST && lcd_addr <= ROW0_LAST) begin
                  hit      = 1'b1;
                  cell_idx = {1'b0, lcd_addr[2:0]};
                end else if (lcd_addr >= ROW1_FIRST && lcd_addr <= ROW1_LAST) begin
                  hit      = 1'b1;
                  cell_idx = {1'b1, lcd_addr[2:0]};
                end
                if (hit) begin
                  r.redraw_request    = (lcd_cells[cell_idx] != lcd_byte);
                  lcd_cells[cell_idx] = lcd_byte;
                  r.display_write     = 1'b1;
                  r.display_pos       = cell_idx;
                  r.display_char      = lcd_byte;
                end
                lcd_addr = lcd_addr + 8'd1;
              end
            end
            lcd_low_phase = ~lcd_low_phase;
          end
        end
      end
    endcase
    r.byte_value      = lcd_byte;
    r.current_address = lcd_addr;
    return r;
  endfunction

  function automatic string show_result(input lcdn_pkg::result_t r);
    return $sformatf("done=%0d byte=%h wr=%0d pos=%0d chr=%h redraw=%0d addr=%h pad=%0d",
                     r.byte_complete, r.byte_value, r.display_write, r.display_pos,
                     r.display_char, r.redraw_request, r.current_address, r.pad);
  endfunction

  // sample both handshakes and track the model
  always @(posedge clk) begin
    in_fire = rst_n && in_tvalid && in_tready;
    if (in_fire) begin
      lcd_result_queue.push_back(
        predict_pin_event(lcdn_pkg::action_t'(in_tdata[1:0]), in_tdata[5:2]));
    end
    if (rst_n && out_tvalid && out_tready) begin
      got_result = lcdn_pkg::result_t'(out_tdata);
      if (lcd_result_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result beat: %s", show_result(got_result));
        end
      end else begin
        want_result = lcd_result_queue.pop_front();
        if (got_result !== want_result) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch expected: %s", show_result(want_result));
            $display("         actual:   %s", show_result(got_result));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("testbench failed");
      $finish;
    end
  end

  // driver: hold a beat until taken, then maybe advance
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (pin_event_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= pin_event_queue.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: long hold-off first, random stalls otherwise
  always @(negedge clk) begin
    if (holdoff_left > 0) begin
      holdoff_left = holdoff_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic push_event(input lcdn_pkg::action_t act, input logic [3:0] val);
    pin_event_queue.push_back({2'b00, val, act});
    gen_count++;
    if (act == lcdn_pkg::ACT_SET_EN && val != gen_en) begin
      if (val != EN_HIGH) begin
        gen_phase = ~gen_phase;
      end
      gen_en = val;
    end
  endtask

  // one nibble take: mostly a high-low pulse, sometimes an odd level
  task automatic push_strobe();
    logic [3:0] lvl;
    if ($urandom_range(3) != 0) begin
      push_event(lcdn_pkg::ACT_SET_EN, EN_HIGH);
      push_event(lcdn_pkg::ACT_SET_EN, 4'd0);
    end else begin
      do begin
        lvl = 4'($urandom_range(15));
      end while (lvl == EN_HIGH || lvl == gen_en);
      push_event(lcdn_pkg::ACT_SET_EN, lvl);
    end
  endtask

  task automatic push_byte(input bit rs, input bit rw, input logic [7:0] b);
    // realign to the high nibble if noise left us mid-byte
    if (gen_phase) begin
      push_event(lcdn_pkg::ACT_NIBBLE, 4'($urandom_range(15)));
      push_strobe();
    end
    push_event(lcdn_pkg::ACT_SET_RS, rs ? 4'($urandom_range(1, 15)) : 4'd0);
    push_event(lcdn_pkg::ACT_SET_RW, rw ? 4'($urandom_range(1, 15)) : 4'd0);
    push_event(lcdn_pkg::ACT_NIBBLE, b[7:4]);
    push_strobe();
    push_event(lcdn_pkg::ACT_NIBBLE, b[3:0]);
    push_strobe();
  endtask

  task automatic push_random(input int n);
    int         stop_at;
    int         pick;
    int         run;
    logic [7:0] b;
    stop_at = gen_count + n;
    while (gen_count < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        pick = $urandom_range(9);
        if (pick < 4) begin
          b = ROW0_FIRST + 8'($urandom_range(7));
        end else if (pick < 8) begin
          b = ROW1_FIRST + 8'($urandom_range(7));
        end else if (pick == 8) begin
          b = 8'hFF - 8'($urandom_range(2));
        end else begin
          b = 8'($urandom_range(255));
        end
        push_byte(1'b0, 1'b0, b);
        run = $urandom_range(1, 10);
        repeat (run) begin
          // narrow data set so repeated writes can leave the cell unchanged
          b = $urandom_range(1) ? 8'($urandom_range(255)) : 8'h30 + 8'($urandom_range(3));
          push_byte(1'b1, 1'b0, b);
        end
      end else if (pick < 75) begin
        push_byte($urandom_range(1), 1'b1, 8'($urandom_range(255)));
      end else if (pick < 85) begin
        push_byte(1'b1, 1'b0, 8'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(1, 3)) begin
          push_event(lcdn_pkg::action_t'($urandom_range(3)), 4'($urandom_range(15)));
        end
      end
    end
  endtask

  task automatic wait_drained();
    do begin
      @(posedge clk);
    end while (!(pin_event_queue.size() == 0 && !in_tvalid && lcd_result_queue.size() == 0));
  endtask

  initial begin
    lcd_rs        = 1'b0;
    lcd_rw        = 1'b0;
    lcd_en        = 4'd0;
    lcd_nibble    = 4'd0;
    lcd_byte      = 8'h00;
    lcd_low_phase = 1'b0;
    lcd_addr      = 8'h00;
    for (int i = 0; i < lcdn_pkg::DISPLAY_CELLS; i++) begin
      lcd_cells[i] = 8'h00;
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // no idling; receiver holds off while the sender keeps offering
    holdoff_left = 80;
    push_event(lcdn_pkg::ACT_SET_RS, 4'd0);
    push_event(lcdn_pkg::ACT_SET_RW, 4'd0);
    push_event(lcdn_pkg::ACT_NIBBLE, 4'hF);
    push_event(lcdn_pkg::ACT_SET_EN, 4'hF);
    push_event(lcdn_pkg::ACT_SET_EN, 4'hF);
    push_event(lcdn_pkg::ACT_NIBBLE, 4'hF);
    push_event(lcdn_pkg::ACT_SET_EN, 4'd0);
    push_event(lcdn_pkg::ACT_SET_RS, 4'hA);
    push_event(lcdn_pkg::ACT_NIBBLE, 4'h5);
    push_event(lcdn_pkg::ACT_SET_EN, EN_HIGH);
    push_event(lcdn_pkg::ACT_SET_EN, 4'd0);
    push_event(lcdn_pkg::ACT_NIBBLE, 4'hA);
    push_event(lcdn_pkg::ACT_SET_EN, EN_HIGH);
    push_event(lcdn_pkg::ACT_SET_EN, 4'd0);
    push_event(lcdn_pkg::ACT_SET_RS, 4'd0);
    push_event(lcdn_pkg::ACT_NIBBLE, 4'hC);
    push_event(lcdn_pkg::ACT_SET_EN, 4'd2);
    push_event(lcdn_pkg::ACT_NIBBLE, 4'h7);
    push_event(lcdn_pkg::ACT_SET_EN, 4'd0);
    push_event(lcdn_pkg::ACT_SET_RS, 4'd1);
    push_event(lcdn_pkg::ACT_NIBBLE, 4'h0);
    push_event(lcdn_pkg::ACT_SET_EN, 4'd8);
    push_event(lcdn_pkg::ACT_SET_EN, 4'd0);
    push_event(lcdn_pkg::ACT_SET_RW, 4'd1);
    push_event(lcdn_pkg::ACT_NIBBLE, 4'h3);
    push_event(lcdn_pkg::ACT_SET_EN, 4'd3);
    push_event(lcdn_pkg::ACT_NIBBLE, 4'h9);
    push_event(lcdn_pkg::ACT_SET_EN, 4'd0);
    push_event(lcdn_pkg::ACT_SET_RW, 4'd0);
    push_random(360);
    wait_drained();

    send_idle_pct  = 84;
    recv_stall_pct = 0;
    push_random(365);
    wait_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 84;
    push_random(365);
    wait_drained();

    send_idle_pct  = 28;
    recv_stall_pct = 28;
    push_random(360);
    wait_drained();

    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
